// ===== src/ctws_pkg.sv =====
// Package for the compact-target work accumulator.
// Holds the transaction payload types, the controller/datapath interface structs and sizes.
// No dependencies.
`default_nettype none

package ctws_pkg;

	// Width of the expanded target, divider and running sum
	localparam int unsigned SUM_W = 256;
	// One quotient bit per divider step
	localparam int unsigned DIV_STEPS = SUM_W;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);

	// Input transaction: one compact difficulty word
	typedef struct packed {
		logic [31:0] target_bits;
		logic        last_header;
	} hdr_t;

	// Output transaction: the 256-bit work sum as four 64-bit words
	typedef struct packed {
		logic [63:0] work_word3;
		logic [63:0] work_word2;
		logic [63:0] work_word1;
		logic [63:0] work_word0;
	} work_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture; // latch the incoming word
		logic load;    // expand the target, set up the divider
		logic step;    // one restoring division step
		logic acc;     // add the work into the sum, emit on the last word
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic target_ok; // word carries real work
		logic last;      // latched word ends the run
	} sts_t;

endpackage

`default_nettype wire

// ===== src/ctws_ctrl.sv =====
// Controller state machine of the compact-target work accumulator.
// Sequences capture, target expansion, the divider loop and accumulation; uses ctws_pkg.
`default_nettype none

module ctws_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          hdr_valid,
	output logic               hdr_stall,
	output logic               work_valid,
	input  wire logic          work_stall,
	input  wire ctws_pkg::sts_t sts,
	output ctws_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_ACC  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [ctws_pkg::CNT_W-1:0] cnt_q;
	logic work_valid_q;
	logic slot_free;
	logic emit;
	logic div_done;

	assign slot_free = !work_valid_q || !work_stall;
	assign div_done  = (cnt_q == ctws_pkg::CNT_W'(ctws_pkg::DIV_STEPS - 1));
	assign hdr_stall  = (state_q != ST_IDLE);
	assign work_valid = work_valid_q;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		emit        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (hdr_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = sts.target_ok ? ST_DIV : ST_ACC;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (div_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				// on the last word, hold until the output register can take the sum
				if (!sts.last || slot_free) begin
					cmd.acc = 1'b1;
					emit    = sts.last;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			work_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit) begin
				work_valid_q <= 1'b1;
			end else if (!work_stall) begin
				work_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/ctws_dp.sv =====
// Datapath of the compact-target work accumulator.
// Target expansion, restoring divider, 256-bit running sum and output register; uses ctws_pkg.
`default_nettype none

module ctws_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ctws_pkg::cmd_t  cmd,
	output ctws_pkg::sts_t       sts,
	input  wire ctws_pkg::hdr_t  hdr,
	output ctws_pkg::work_t      work
);

	localparam int unsigned W = ctws_pkg::SUM_W;

	logic [31:0]  tbits_q;
	logic         last_q;
	logic         ok_q;
	logic [W-1:0] den_q;
	logic [W-1:0] nq_q;   // numerator in, quotient out
	logic [W-1:0] rem_q;
	logic [W-1:0] sum_q;
	ctws_pkg::work_t work_q;

	logic [7:0]   exp_w;
	logic [22:0]  mant_adj;
	logic [4:0]   byte_sh;
	logic         tgt_zero;
	logic         tgt_ovf;
	logic         tgt_ok;
	logic [W-1:0] target;
	logic [W+1:0] diff;
	logic         ge;
	logic [W-1:0] sum_next;

	// Expand the compact word
	always_comb begin
		exp_w = tbits_q[31:24];
		if (exp_w <= 8'd3) begin
			mant_adj = tbits_q[22:0] >> {(2'd3 - exp_w[1:0]), 3'b000};
			byte_sh  = 5'd0;
		end else begin
			mant_adj = tbits_q[22:0];
			byte_sh  = exp_w[4:0] - 5'd3;
		end
		tgt_zero = (mant_adj == 23'd0);
		tgt_ovf  = (exp_w > 8'd34) ||
		           ((mant_adj > 23'h0000ff) && (exp_w > 8'd33)) ||
		           ((mant_adj > 23'h00ffff) && (exp_w > 8'd32));
		tgt_ok   = !tgt_zero && !tbits_q[23] && !tgt_ovf;
		target   = {{(W-23){1'b0}}, mant_adj} << {byte_sh, 3'b000};
	end

	// Restoring divider trial subtract
	assign diff = {1'b0, rem_q, nq_q[W-1]} - {2'b00, den_q};
	assign ge   = !diff[W+1];

	// Work = quotient + 1, only for a valid target
	assign sum_next = sum_q + (ok_q ? nq_q : '0) + W'(ok_q);

	assign sts.target_ok = tgt_ok;
	assign sts.last      = last_q;
	assign work          = work_q;

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tbits_q <= hdr.target_bits;
			last_q  <= hdr.last_header;
		end
		if (cmd.load) begin
			ok_q  <= tgt_ok;
			den_q <= target + 1'b1;
			nq_q  <= ~target;
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= ge ? diff[W-1:0] : {rem_q[W-2:0], nq_q[W-1]};
			nq_q  <= {nq_q[W-2:0], ge};
		end
		if (cmd.acc && last_q) begin
			work_q.work_word0 <= sum_next[63:0];
			work_q.work_word1 <= sum_next[127:64];
			work_q.work_word2 <= sum_next[191:128];
			work_q.work_word3 <= sum_next[255:192];
		end
	end

	// Running sum, cleared after each run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= last_q ? '0 : sum_next;
		end
	end

endmodule

`default_nettype wire

// ===== src/compact_target_work_sum.sv =====
// A word with work is captured, its target expanded, divided by the restoring divider at
// one quotient bit per cycle, and its work accumulated; a word that adds nothing skips
// the divider. The input stalls until the current word is finished, one word at a time.
// The result waits in an output register while the next word is taken.
// Reset (arst_n low) clears the controller, output valid and the running sum to zero.
// Top level: joins the controller (ctws_ctrl) and datapath (ctws_dp); uses ctws_pkg.
`default_nettype none

module compact_target_work_sum (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             hdr_valid,
	output logic                  hdr_stall,
	input  wire ctws_pkg::hdr_t   hdr,
	output logic                  work_valid,
	input  wire logic             work_stall,
	output ctws_pkg::work_t       work
);

	ctws_pkg::cmd_t cmd;
	ctws_pkg::sts_t sts;

	ctws_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr_valid  (hdr_valid),
		.hdr_stall  (hdr_stall),
		.work_valid (work_valid),
		.work_stall (work_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	ctws_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.hdr    (hdr),
		.work   (work)
	);

endmodule

`default_nettype wire

// ===== src/ctws_checker.sv =====
// Port-level checker for the compact-target work accumulator, bound to the top level.
// Uses ctws_pkg types only.
`default_nettype none

module ctws_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            hdr_valid,
	input wire logic            hdr_stall,
	input wire ctws_pkg::hdr_t  hdr,
	input wire logic            work_valid,
	input wire logic            work_stall,
	input wire ctws_pkg::work_t work
);

	// A stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		work_valid && work_stall |=> work_valid)
		else $error("work_valid dropped while stalled");

	// A stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		work_valid && work_stall |=> $stable(work))
		else $error("work changed while stalled");

	// One word at a time: busy right after a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_stall |=> hdr_stall)
		else $error("input taken again before the word finished");

	// No result appears in the cycle right after a transaction
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && !hdr_stall |=> !$rose(work_valid))
		else $error("result appeared too early");

endmodule

bind compact_target_work_sum ctws_checker u_ctws_checker (.*);

`default_nettype wire
